// ----- sv/slpp_pkg.sv -----
// ----------------------------------------------------------------------------
// slpp_pkg
// Types and constants shared by the slew-limited position packetizer.
// ----------------------------------------------------------------------------
package slpp_pkg;

    localparam int POS_W = 12;

    localparam logic [POS_W-1:0] POS_MID = 12'd2048;

    localparam logic [15:0] DEST_ADDR_RST      = 16'hFFFF;
    localparam logic [11:0] STEP_LIMIT_RST     = 12'd50;
    localparam logic [7:0]  REFRESH_PERIOD_RST = 8'd10;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    typedef enum logic [1:0] {
        REG_DEST_ADDR      = 2'd0,
        REG_STEP_LIMIT     = 2'd1,
        REG_REFRESH_PERIOD = 2'd2
    } slpp_reg_t;

    localparam int BASE_IDX_W = 4;
    localparam logic [7:0] FRAME_BASE [16] = '{
        8'h0F, 8'h61, 8'h88, 8'h00, 8'hE4, 8'h3D, 8'hFF, 8'hFF,
        8'h96, 8'hF0, 8'h44, 8'h05, 8'h00, 8'hB7, 8'h00, 8'h00
    };

    localparam int BYTE_LEN     = 0;
    localparam int BYTE_SEQ     = 3;
    localparam int BYTE_DEST_HI = 6;
    localparam int BYTE_DEST_LO = 7;
    localparam int BYTE_POS_HI  = 10;
    localparam int BYTE_POS_LO  = 11;
    localparam int BYTE_CSUM    = 13;

    localparam logic [3:0] POS_HI_TAG = 4'h4;

    typedef struct packed {
        logic             cmd;
        logic [POS_W-1:0] target_value;
    } slpp_in_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       upper_half;
    } slpp_out_t;

    typedef struct packed {
        logic [15:0] dest_addr;
        logic [11:0] step_limit;
        logic [7:0]  refresh_period;
    } slpp_cfg_t;

    typedef struct packed {
        logic [7:0]       seq;
        logic [15:0]      dest_addr;
        logic [POS_W-1:0] pos;
        logic             upper;
    } slpp_desc_t;

endpackage

// ----- sv/slpp_regs.sv -----
// ----------------------------------------------------------------------------
// slpp_regs
// APB configuration registers: destination address, step limit, refresh period.
// ----------------------------------------------------------------------------
module slpp_regs
    import slpp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output slpp_cfg_t   cfg
);

    slpp_cfg_t cfg_reg;
    slpp_cfg_t cfg_next;
    logic      wr_en;
    slpp_reg_t reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = slpp_reg_t'(paddr[3:2]);
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_DEST_ADDR:      cfg_next.dest_addr      = pwdata[15:0];
                REG_STEP_LIMIT:     cfg_next.step_limit     = pwdata[11:0];
                REG_REFRESH_PERIOD: cfg_next.refresh_period = pwdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DEST_ADDR:      prdata = {16'd0, cfg_reg.dest_addr};
            REG_STEP_LIMIT:     prdata = {20'd0, cfg_reg.step_limit};
            REG_REFRESH_PERIOD: prdata = {24'd0, cfg_reg.refresh_period};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_addr      <= DEST_ADDR_RST;
            cfg_reg.step_limit     <= STEP_LIMIT_RST;
            cfg_reg.refresh_period <= REFRESH_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/slpp_front.sv -----
// ----------------------------------------------------------------------------
// slpp_front
// Accepts commands, runs the slew step and refresh timer, and issues one
// frame descriptor per transmitting tick.
// ----------------------------------------------------------------------------
module slpp_front
    import slpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  slpp_cfg_t  cfg,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  slpp_in_t   cmd_item,
    input  logic       q_full,
    output logic       q_push,
    output slpp_desc_t q_desc
);

    logic [POS_W-1:0] target_reg, target_next;
    logic [POS_W-1:0] cur_reg, cur_next;
    logic             changed_reg, changed_next;
    logic [7:0]       seq_reg, seq_next;
    logic [7:0]       phase_reg, phase_next;
    logic             dither_reg, dither_next;

    logic             accept;
    logic             tick;
    logic [POS_W-1:0] gap;
    logic [POS_W-1:0] slew_pos;
    logic             moved;
    logic             send;
    logic [8:0]       phase_inc;

    assign cmd_stall = q_full;
    assign accept    = cmd_valid && !cmd_stall;
    assign tick      = (cmd_item.cmd == CMD_TICK);

    always_comb
    begin
        gap      = '0;
        slew_pos = cur_reg;
        moved    = 1'b0;
        if (target_reg > cur_reg)
        begin
            gap      = target_reg - cur_reg;
            slew_pos = (gap > cfg.step_limit) ? cur_reg + cfg.step_limit : target_reg;
            moved    = 1'b1;
        end
        else if (target_reg < cur_reg)
        begin
            gap      = cur_reg - target_reg;
            slew_pos = (gap > cfg.step_limit) ? cur_reg - cfg.step_limit : target_reg;
            moved    = 1'b1;
        end
    end

    assign send      = changed_reg || moved || (phase_reg == 8'd0);
    assign phase_inc = {1'b0, phase_reg} + 9'd1;
    assign q_push    = accept && tick && send;

    always_comb
    begin
        q_desc.seq       = seq_reg;
        q_desc.dest_addr = cfg.dest_addr;
        q_desc.pos       = slew_pos + {{(POS_W-1){1'b0}}, dither_reg};
        q_desc.upper     = (slew_pos > POS_MID);
    end

    always_comb
    begin
        target_next  = target_reg;
        cur_next     = cur_reg;
        changed_next = changed_reg;
        seq_next     = seq_reg;
        phase_next   = phase_reg;
        dither_next  = dither_reg;
        if (accept)
        begin
            if (!tick)
            begin
                target_next  = cmd_item.target_value;
                changed_next = 1'b1;
            end
            else
            begin
                cur_next     = slew_pos;
                changed_next = send ? 1'b0 : (changed_reg || moved);
                seq_next     = send ? seq_reg + 8'd1 : seq_reg;
                phase_next   = (phase_inc >= {1'b0, cfg.refresh_period}) ? 8'd0
                                                                         : phase_inc[7:0];
                dither_next  = !dither_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= POS_MID;
            cur_reg     <= POS_MID;
            changed_reg <= 1'b0;
            seq_reg     <= 8'd0;
            phase_reg   <= 8'd0;
            dither_reg  <= 1'b0;
        end
        else
        begin
            target_reg  <= target_next;
            cur_reg     <= cur_next;
            changed_reg <= changed_next;
            seq_reg     <= seq_next;
            phase_reg   <= phase_next;
            dither_reg  <= dither_next;
        end
    end

`ifndef SYNTHESIS
    a_dither_toggles: assert property (@(posedge clk) disable iff (!rst_n)
        accept && tick |=> dither_reg != $past(dither_reg))
        else $error("dither bit did not toggle on tick");

    a_seq_advances: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> seq_reg == $past(seq_reg) + 8'd1 && !changed_reg)
        else $error("sequence number or change flag wrong after send");
`endif

endmodule

// ----- sv/slpp_queue.sv -----
// ----------------------------------------------------------------------------
// slpp_queue
// Two-entry descriptor FIFO between the command front end and the serializer.
// ----------------------------------------------------------------------------
module slpp_queue
    import slpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  slpp_desc_t push_desc,
    input  logic       pop,
    output logic       full,
    output logic       head_valid,
    output slpp_desc_t head_desc
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    slpp_desc_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

// ----- sv/slpp_back.sv -----
// ----------------------------------------------------------------------------
// slpp_back
// Frame serializer: walks the head descriptor one byte per cycle, while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module slpp_back
    import slpp_pkg::*;
#(
    parameter int FRAME_BYTES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  slpp_desc_t head_desc,
    output logic       pop,
    output logic       frame_valid,
    input  logic       frame_stall,
    output slpp_out_t  frame_item
);

    localparam int IDX_W = $clog2(FRAME_BYTES);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    slpp_out_t        out_reg, out_next;

    logic             advance;
    logic             last;
    logic [7:0]       pos_hi;
    logic [7:0]       pos_lo;
    logic [7:0]       csum;
    logic [7:0]       byte_val;

    assign advance = head_valid && (!out_valid_reg || !frame_stall);
    assign last    = (idx_reg == IDX_W'(FRAME_BYTES - 1));
    assign pop     = advance && last;

    assign pos_hi = {POS_HI_TAG, head_desc.pos[11:8]};
    assign pos_lo = head_desc.pos[7:0];
    assign csum   = 8'd0 - pos_hi - pos_lo;

    always_comb
    begin
        case (idx_reg)
            IDX_W'(BYTE_LEN):     byte_val = 8'(FRAME_BYTES - 1);
            IDX_W'(BYTE_SEQ):     byte_val = head_desc.seq;
            IDX_W'(BYTE_DEST_HI): byte_val = head_desc.dest_addr[15:8];
            IDX_W'(BYTE_DEST_LO): byte_val = head_desc.dest_addr[7:0];
            IDX_W'(BYTE_POS_HI):  byte_val = pos_hi;
            IDX_W'(BYTE_POS_LO):  byte_val = pos_lo;
            IDX_W'(BYTE_CSUM):    byte_val = csum;
            default:              byte_val = FRAME_BASE[BASE_IDX_W'(idx_reg)];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_next.frame_byte = byte_val;
            out_next.last_byte  = last;
            out_next.upper_half = head_desc.upper;
            out_valid_next      = 1'b1;
            idx_next            = last ? '0 : idx_reg + IDX_W'(1);
        end
        else if (!frame_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign frame_valid = out_valid_reg;
    assign frame_item  = out_reg;

`ifndef SYNTHESIS
    a_mid_frame_head: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != '0 |-> head_valid)
        else $error("frame in progress without a descriptor");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last |=> idx_reg == $past(idx_reg) + IDX_W'(1))
        else $error("byte index did not advance");
`endif

endmodule

// ----- sv/slew_limited_position_packetizer.sv -----
// ----------------------------------------------------------------------------
// slew_limited_position_packetizer
// Slew-limited position tracker that emits a radio frame per transmitting tick.
// ----------------------------------------------------------------------------
// A tick's descriptor is queued, then serialized into a registered output stage.
// Throughput: one command transaction per cycle while the descriptor queue has
//   room; frames leave at one byte per cycle while frame_stall is low.
// The two-entry descriptor queue stalls commands only when two frames wait.
// Reset: asynchronous; position and target to 2048, counters and flags to 0,
//   registers to 0xFFFF, 50, 10.
module slew_limited_position_packetizer
    import slpp_pkg::*;
#(
    parameter int FRAME_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  slpp_in_t    cmd_item,
    output logic        frame_valid,
    input  logic        frame_stall,
    output slpp_out_t   frame_item
);

    slpp_cfg_t  cfg;
    logic       q_full;
    logic       q_push;
    slpp_desc_t q_desc;
    logic       q_pop;
    logic       head_valid;
    slpp_desc_t head_desc;

    slpp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (q_desc)
    );

    slpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (q_desc),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    slpp_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_desc   (head_desc),
        .pop         (q_pop),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_item  (frame_item)
    );

endmodule

// ----- tb/slpp_frame_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpp_frame_checker
// Watches the register port and both transaction channels of the slew-limited
// position packetizer. Keeps its own copy of position, target, sequence and
// refresh state and builds the frame bytes that each tick should send. Each
// accepted output byte is compared against the oldest predicted byte.
// ----------------------------------------------------------------------------
module slpp_frame_checker
    import slpp_pkg::*;
#(
    parameter int FRAME_BYTES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  slpp_in_t    cmd_item,
    input  logic        frame_valid,
    input  logic        frame_stall,
    input  slpp_out_t   frame_item,
    output int          mismatches,
    output int          bytes_checked,
    output int          bytes_pending
);

    slpp_cfg_t        cfg;
    logic [POS_W-1:0] target_pos;
    logic [POS_W-1:0] cur_pos;
    logic             changed;
    logic             dither;
    logic [7:0]       seq;
    logic [7:0]       phase;
    slpp_out_t        expected_bytes[$];

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: frame mismatch: %s", $realtime, msg);
    endtask

    task automatic apply_command(slpp_in_t item);
        logic [POS_W-1:0] gap;
        logic [POS_W-1:0] p;
        logic [7:0]       b [16];
        logic             up;
        logic [8:0]       nxt;
        slpp_out_t        e;
        if (item.cmd == CMD_SET)
        begin
            target_pos = item.target_value;
            changed    = 1'b1;
            return;
        end
        if (cur_pos != target_pos)
        begin
            if (target_pos > cur_pos)
            begin
                gap     = target_pos - cur_pos;
                cur_pos = (gap > cfg.step_limit) ? cur_pos + cfg.step_limit : target_pos;
            end
            else
            begin
                gap     = cur_pos - target_pos;
                cur_pos = (gap > cfg.step_limit) ? cur_pos - cfg.step_limit : target_pos;
            end
            changed = 1'b1;
        end
        if (changed || phase == 8'd0)
        begin
            b = FRAME_BASE;
            p = cur_pos + POS_W'(dither);
            b[BYTE_LEN]       = 8'(FRAME_BYTES - 1);
            b[BYTE_SEQ]       = seq;
            b[BYTE_DEST_HI]   = cfg.dest_addr[15:8];
            b[BYTE_DEST_LO]   = cfg.dest_addr[7:0];
            b[BYTE_POS_HI]    = {POS_HI_TAG, p[11:8]};
            b[BYTE_POS_LO]    = p[7:0];
            b[BYTE_POS_LO+1]  = 8'h00;
            b[BYTE_CSUM]      = 8'h00 - b[BYTE_POS_HI] - b[BYTE_POS_LO] - b[BYTE_POS_LO+1];
            up = (cur_pos > POS_MID);
            for (int i = 0; i < FRAME_BYTES && i < 16; i++)
            begin
                e.frame_byte = b[i];
                e.last_byte  = (i == FRAME_BYTES - 1);
                e.upper_half = up;
                expected_bytes.push_back(e);
            end
            seq     = seq + 8'd1;
            changed = 1'b0;
        end
        nxt    = {1'b0, phase} + 9'd1;
        phase  = (nxt >= {1'b0, cfg.refresh_period}) ? 8'd0 : nxt[7:0];
        dither = ~dither;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slpp_out_t exp_b;
        if (!rst_n)
        begin
            cfg.dest_addr      = DEST_ADDR_RST;
            cfg.step_limit     = STEP_LIMIT_RST;
            cfg.refresh_period = REFRESH_PERIOD_RST;
            target_pos    = POS_MID;
            cur_pos       = POS_MID;
            changed       = 1'b0;
            dither        = 1'b0;
            seq           = 8'd0;
            phase         = 8'd0;
            mismatches    = 0;
            bytes_checked = 0;
            bytes_pending = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (slpp_reg_t'(paddr[3:2]))
                    REG_DEST_ADDR:      cfg.dest_addr      = pwdata[15:0];
                    REG_STEP_LIMIT:     cfg.step_limit     = pwdata[11:0];
                    REG_REFRESH_PERIOD: cfg.refresh_period = pwdata[7:0];
                    default:            ;
                endcase
            end
            if (frame_valid && !frame_stall)
            begin
                if (expected_bytes.size() == 0)
                    report($sformatf("unexpected byte %02h last %0b upper %0b",
                        frame_item.frame_byte, frame_item.last_byte, frame_item.upper_half));
                else
                begin
                    exp_b = expected_bytes.pop_front();
                    bytes_checked++;
                    if (frame_item.frame_byte !== exp_b.frame_byte)
                        report($sformatf("frame_byte expected %02h got %02h",
                            exp_b.frame_byte, frame_item.frame_byte));
                    if (frame_item.last_byte !== exp_b.last_byte)
                        report($sformatf("last_byte expected %0b got %0b",
                            exp_b.last_byte, frame_item.last_byte));
                    if (frame_item.upper_half !== exp_b.upper_half)
                        report($sformatf("upper_half expected %0b got %0b",
                            exp_b.upper_half, frame_item.upper_half));
                end
            end
            if (cmd_valid && !cmd_stall)
                apply_command(cmd_item);
            bytes_pending = expected_bytes.size();
        end
    end

endmodule

// ----- tb/slew_limited_position_packetizer_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slew_limited_position_packetizer_test
// Drives set-target and tick transactions and register writes into the
// packetizer: a directed pass over reset values, register extremes and
// position wrap, then random traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module slew_limited_position_packetizer_test;
    import slpp_pkg::*;

    localparam int FRAME_BYTES   = 16;
    localparam int DRAIN_CYCLES  = 20;
    localparam int SETTLE_LIMIT  = 20000;
    localparam int PHASE_ITEMS   = 88;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    slpp_in_t    cmd_item  = '0;
    logic        frame_valid;
    logic        frame_stall = 1'b0;
    slpp_out_t   frame_item;

    int mismatches;
    int bytes_checked;
    int bytes_pending;
    int idle_pct      = 0;
    int stall_pct     = 0;
    int ticks_sent    = 0;
    int targets_sent  = 0;
    int settings_used = 0;

    always #1 clk = ~clk;

    slew_limited_position_packetizer #(.FRAME_BYTES(FRAME_BYTES)) dut (.*);

    slpp_frame_checker #(.FRAME_BYTES(FRAME_BYTES)) frame_check (.*);

    always @(posedge clk)
        frame_stall <= ($urandom_range(99) < stall_pct);

    task automatic write_reg(slpp_reg_t r, logic [31:0] v);
        logic rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = pready;
            @(posedge clk);
        end
        while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // upper register bits carry noise; the block keeps only the low bits
    task automatic configure(logic [15:0] dest, logic [11:0] step, logic [7:0] period);
        logic [31:0] noise;
        noise = $urandom;
        write_reg(REG_DEST_ADDR, {noise[31:16], dest});
        write_reg(REG_STEP_LIMIT, {noise[31:12], step});
        write_reg(REG_REFRESH_PERIOD, {noise[31:8], period});
        settings_used++;
    endtask

    task automatic send(logic c, logic [POS_W-1:0] v);
        logic ok;
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            cmd_item  <= slpp_in_t'($urandom);
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= '{cmd: c, target_value: v};
        do
        begin
            @(negedge clk);
            ok = !cmd_stall;
            @(posedge clk);
        end
        while (!ok);
        if (c == CMD_SET)
            targets_sent++;
        else
            ticks_sent++;
    endtask

    task automatic tick(int n);
        repeat (n) send(CMD_TICK, POS_W'($urandom));
    endtask

    // a set-target causes no frame, so give the block a drain time past the last byte
    task automatic settle();
        int waited;
        waited = 0;
        cmd_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (bytes_pending != 0 && waited < SETTLE_LIMIT);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int idle, int stall);
        logic [11:0] step;
        logic [7:0]  period;
        int          sel;
        idle_pct  = idle;
        stall_pct = stall;
        settle();
        sel = $urandom_range(9);
        step = (sel == 0) ? 12'd4095 : (sel == 1) ? 12'd0 : 12'($urandom_range(400, 1));
        sel = $urandom_range(9);
        period = (sel == 0) ? 8'd255 : (sel == 1) ? 8'd0 : 8'($urandom_range(16, 1));
        configure(16'($urandom), step, period);
        repeat (PHASE_ITEMS)
        begin
            sel = $urandom_range(99);
            if (sel < 5)
                send(CMD_SET, 12'd0);
            else if (sel < 10)
                send(CMD_SET, 12'd4095);
            else if (sel < 30)
                send(CMD_SET, POS_W'($urandom));
            else
                tick(1);
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: first tick sends on phase zero, second stays quiet
        tick(2);

        settle();
        configure(16'h0000, 12'd4095, 8'd1);
        send(CMD_SET, 12'd4095);
        tick(3);                       // position 4095 with both dither values
        send(CMD_SET, 12'd0);
        tick(2);

        settle();
        configure(16'hFFFF, 12'd0, 8'd0);
        send(CMD_SET, 12'd2049);
        tick(2);

        settle();
        configure(16'hA55A, 12'd1, 8'd255);
        send(CMD_SET, 12'd3);
        tick(4);

        settle();
        configure(16'h1234, 12'd50, 8'd2);   // period now below the phase
        tick(3);

        random_phase(0, 0);
        random_phase(59, 0);
        random_phase(0, 59);
        random_phase(18, 18);

        settle();
        $display("covered %0d ticks and %0d target updates over %0d register settings",
            ticks_sent, targets_sent, settings_used);
        $display("%0d frame bytes checked, %0d mismatches, %0d bytes never seen",
            bytes_checked, mismatches, bytes_pending);
        if (mismatches == 0 && bytes_pending == 0)
            $display("slew_limited_position_packetizer_test OK");
        else
            $display("slew_limited_position_packetizer_test NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d bytes still expected", bytes_pending);
        $display("slew_limited_position_packetizer_test NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/slpp_pkg.sv
sv/slpp_regs.sv
sv/slpp_front.sv
sv/slpp_queue.sv
sv/slpp_back.sv
sv/slew_limited_position_packetizer.sv
tb/slpp_frame_checker.sv
tb/slew_limited_position_packetizer_test.sv
